@@ rtl/sfdc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfdc_pkg
// Shared constants and types for the sensor frame deframer and checksum core.
// ----------------------------------------------------------------------------
package sfdc_pkg;

   localparam int unsigned FRAME_BYTES   = 40;
   localparam int unsigned PAYLOAD_WORDS = 9;
   localparam int unsigned WORD_BITS     = 32;
   localparam int unsigned COUNT_BITS    = 6;
   localparam int unsigned WIDX_BITS     = $clog2(PAYLOAD_WORDS);
   localparam int unsigned DATA_BITS     = PAYLOAD_WORDS * WORD_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] POS_LAST_PAY = COUNT_BITS'(4 * PAYLOAD_WORDS);
   localparam logic [COUNT_BITS-1:0] POS_SUM_LOW  = COUNT_BITS'(FRAME_BYTES - 3);
   localparam logic [COUNT_BITS-1:0] POS_SUM_HIGH = COUNT_BITS'(FRAME_BYTES - 2);
   localparam logic [COUNT_BITS-1:0] COUNT_KEEP   = COUNT_BITS'(FRAME_BYTES);

   localparam logic [7:0] START_MARKER_RESET = 8'hAA;
   localparam logic [7:0] END_MARKER_RESET   = 8'hFF;

   typedef enum logic {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] words;
      logic                 checksum_ok;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/sensor_frame_deframer_checksum_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_deframer_checksum_core
// Start/end byte deframer with nine 32-bit payload words and a 16-bit sum.
// ----------------------------------------------------------------------------
// One received byte is taken per request, one every clock cycle while
// req_tready is high. The frame state (position, sum, payload words)
// updates in the cycle the byte is accepted. A kept frame shows its
// result on the rsp side in the cycle after its end byte when the output
// register is free, later while an earlier result still waits there. A
// two-entry output buffer (output register plus skid) lets the byte
// stream keep flowing while a result waits; req_tready drops only while
// both entries hold results. Frames of any length other than 40 bytes
// give no result. The marker registers are written through csr_.
module sensor_frame_deframer_checksum_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [7:0]   csr_wdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte[7:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [287:0]      rsp_tdata,   // accel_x, accel_y, accel_z, gyro_x,
                                          // gyro_y, gyro_z, mag_x, mag_y, mag_z
   output logic              rsp_tuser    // checksum_ok
);

   localparam int unsigned CB = sfdc_pkg::COUNT_BITS;
   localparam int unsigned WB = sfdc_pkg::WORD_BITS;
   localparam int unsigned NW = sfdc_pkg::PAYLOAD_WORDS;
   localparam int unsigned IB = sfdc_pkg::WIDX_BITS;

   logic [7:0]    start_marker_ff;
   logic [7:0]    end_marker_ff;

   logic          in_frame_ff, in_frame_in;
   logic [CB-1:0] byte_count_ff, byte_count_in;
   logic [15:0]   running_sum_ff, running_sum_in;
   logic [7:0]    sum_low_ff, sum_low_in;
   logic [7:0]    sum_high_ff, sum_high_in;
   logic [WB-1:0] words_ff [NW];
   logic [WB-1:0] words_in [NW];

   sfdc_pkg::result_type out_ff, out_in, skid_ff, skid_in, result;
   logic          out_valid_ff, out_valid_in;
   logic          skid_valid_ff, skid_valid_in;

   logic          accept;
   logic          result_valid;
   logic [CB-1:0] pos_next;
   logic [CB-1:0] offset;
   logic [IB-1:0] word_idx;
   logic [1:0]    byte_idx;
   logic          pay_hit;
   logic          ok;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.words;
   assign rsp_tuser  = out_ff.checksum_ok;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= sfdc_pkg::START_MARKER_RESET;
         end_marker_ff   <= sfdc_pkg::END_MARKER_RESET;
      end else if (csr_we) begin
         unique case (sfdc_pkg::csr_index_type'(csr_addr))
            sfdc_pkg::CSR_START_MARKER: start_marker_ff <= csr_wdata;
            sfdc_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame state
   always_comb begin
      pos_next  = (byte_count_ff == sfdc_pkg::COUNT_MAX) ? sfdc_pkg::COUNT_MAX
                                                         : byte_count_ff + 1'b1;
      offset    = byte_count_ff - 1'b1;
      word_idx  = offset[IB+1:2];
      byte_idx  = offset[1:0];
      pay_hit   = (byte_count_ff >= CB'(1)) && (byte_count_ff <= sfdc_pkg::POS_LAST_PAY);
      ok        = ({sum_high_ff, sum_low_ff} == running_sum_ff);

      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      sum_low_in     = sum_low_ff;
      sum_high_in    = sum_high_ff;
      result_valid   = 1'b0;
      for (int k = 0; k < NW; k++) begin
         words_in[k] = words_ff[k];
      end

      if (accept) begin
         if (!in_frame_ff) begin
            if (req_tdata == start_marker_ff) begin
               in_frame_in    = 1'b1;
               byte_count_in  = CB'(1);
               running_sum_in = '0;
            end
         end else begin
            byte_count_in = pos_next;
            if (req_tdata == end_marker_ff) begin
               in_frame_in  = 1'b0;
               result_valid = (pos_next == sfdc_pkg::COUNT_KEEP);
            end else if (pay_hit) begin
               for (int k = 0; k < NW; k++) begin
                  if (word_idx == IB'(k)) begin
                     words_in[k][byte_idx*8 +: 8] = req_tdata;
                  end
               end
               running_sum_in = running_sum_ff + {8'h00, req_tdata};
            end else if (byte_count_ff == sfdc_pkg::POS_SUM_LOW) begin
               sum_low_in = req_tdata;
            end else if (byte_count_ff == sfdc_pkg::POS_SUM_HIGH) begin
               sum_high_in = req_tdata;
            end
         end
      end

      for (int k = 0; k < NW; k++) begin
         result.words[k*WB +: WB] = ok ? words_ff[k] : '0;
      end
      result.checksum_ok = ok;
   end

   // output buffer
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (result_valid) begin
         if (out_valid_in) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= '0;
         running_sum_ff <= '0;
         sum_low_ff     <= '0;
         sum_high_ff    <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         sum_low_ff     <= sum_low_in;
         sum_high_ff    <= sum_high_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
      for (int k = 0; k < NW; k++) begin
         words_ff[k] <= words_in[k];
      end
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("payload not cleared on checksum mismatch");

   a_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (byte_count_ff != '0))
      else $error("open frame with zero byte count");

   a_result_after_end: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> (rsp_tvalid && !in_frame_ff))
      else $error("kept frame did not reach the output");
`endif

endmodule
`default_nettype wire
